### hw/rtl/traffic_light_pedestrian_sequencer_assert.svh
// assertion macros used by the sequencer top file
`ifndef TRAFFIC_LIGHT_PEDESTRIAN_SEQUENCER_ASSERT_SVH
`define TRAFFIC_LIGHT_PEDESTRIAN_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define TLPS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sequencer assertion failed");

// next-cycle implication
`define TLPS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sequencer assertion failed");

`endif

### hw/rtl/tlps_pkg.sv
`default_nettype none
package tlps_pkg;

   localparam int TICK_COUNT_WIDTH_DEF = 16;
   localparam int CFG_W   = 16;
   localparam int BLINK_W = 4;
   localparam int PHASE_W = 4;
   localparam int CSR_IDX_W = 2;

   // phase codes
   localparam logic [PHASE_W-1:0] PHASE_GREEN       = 4'd0;
   localparam logic [PHASE_W-1:0] PHASE_GREEN_BLINK = 4'd1;
   localparam logic [PHASE_W-1:0] PHASE_RED         = 4'd2;
   localparam logic [PHASE_W-1:0] PHASE_RED_BLINK   = 4'd3;
   localparam logic [PHASE_W-1:0] PHASE_WARN        = 4'd4;
   localparam logic [PHASE_W-1:0] PHASE_WARN_BLINK  = 4'd5;
   localparam logic [PHASE_W-1:0] PHASE_CROSS       = 4'd6;
   localparam logic [PHASE_W-1:0] PHASE_CROSS_BLINK = 4'd7;
   localparam logic [PHASE_W-1:0] PHASE_RESUME      = 4'd8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PHASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARNING     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_HALF  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_COUNT = 2'd3;

   // register reset values
   localparam logic [CFG_W-1:0]   LONG_PHASE_RST  = 16'd5000;
   localparam logic [CFG_W-1:0]   WARNING_RST     = 16'd2000;
   localparam logic [CFG_W-1:0]   BLINK_HALF_RST  = 16'd500;
   localparam logic [BLINK_W-1:0] BLINK_COUNT_RST = 4'd5;

   typedef struct packed {
      logic [CFG_W-1:0]   long_phase_ticks;
      logic [CFG_W-1:0]   warning_ticks;
      logic [CFG_W-1:0]   blink_half_ticks;
      logic [BLINK_W-1:0] blink_cycles;
   } tlps_cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [BLINK_W-1:0] blinks_done;
      logic               yellow_lit;
   } tlps_state_type;

   typedef struct packed {
      logic               car_green;
      logic               car_yellow;
      logic               car_red;
      logic               walk_green;
      logic               walk_yellow;
      logic               walk_red;
      logic [PHASE_W-1:0] phase_code;
   } tlps_result_type;

   function automatic logic is_blink(input logic [PHASE_W-1:0] p);
      return (p == PHASE_GREEN_BLINK) || (p == PHASE_RED_BLINK) ||
             (p == PHASE_WARN_BLINK) || (p == PHASE_CROSS_BLINK);
   endfunction

   function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] p);
      logic [PHASE_W-1:0] n;
      case (p)
         PHASE_GREEN:       n = PHASE_GREEN_BLINK;
         PHASE_GREEN_BLINK: n = PHASE_RED;
         PHASE_RED:         n = PHASE_RED_BLINK;
         PHASE_WARN:        n = PHASE_WARN_BLINK;
         PHASE_WARN_BLINK:  n = PHASE_CROSS;
         PHASE_CROSS:       n = PHASE_CROSS_BLINK;
         PHASE_CROSS_BLINK: n = PHASE_RESUME;
         default:           n = PHASE_GREEN;
      endcase
      return n;
   endfunction

   // a zero length or count behaves as one
   function automatic logic [CFG_W-1:0] min_one_len(input logic [CFG_W-1:0] v);
      return (v == '0) ? CFG_W'(1) : v;
   endfunction

   function automatic logic [BLINK_W-1:0] min_one_cnt(input logic [BLINK_W-1:0] v);
      return (v == '0) ? BLINK_W'(1) : v;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/tlps_csr.sv
`default_nettype none
module tlps_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [tlps_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tlps_pkg::CFG_W-1:0]     csr_wr_data,
   output tlps_pkg::tlps_cfg_type              cfg
);
   import tlps_pkg::*;

   tlps_cfg_type cfg_ff;
   tlps_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LONG_PHASE:  cfg_in.long_phase_ticks = csr_wr_data;
            CSR_WARNING:     cfg_in.warning_ticks    = csr_wr_data;
            CSR_BLINK_HALF:  cfg_in.blink_half_ticks = csr_wr_data;
            CSR_BLINK_COUNT: cfg_in.blink_cycles     = csr_wr_data[BLINK_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_phase_ticks <= LONG_PHASE_RST;
         cfg_ff.warning_ticks    <= WARNING_RST;
         cfg_ff.blink_half_ticks <= BLINK_HALF_RST;
         cfg_ff.blink_cycles     <= BLINK_COUNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### hw/rtl/tlps_step.sv
`default_nettype none
module tlps_step #(
   parameter int TICK_COUNT_WIDTH = tlps_pkg::TICK_COUNT_WIDTH_DEF
) (
   input  wire logic                        press,
   input  wire tlps_pkg::tlps_cfg_type      cfg,
   input  wire tlps_pkg::tlps_state_type    state_cur,
   input  wire logic [TICK_COUNT_WIDTH-1:0] count_cur,
   output tlps_pkg::tlps_state_type         state_nxt,
   output logic [TICK_COUNT_WIDTH-1:0]      count_nxt,
   output tlps_pkg::tlps_result_type        result
);
   import tlps_pkg::*;

   localparam int CMP_W = ((TICK_COUNT_WIDTH > CFG_W) ? TICK_COUNT_WIDTH : CFG_W) + 1;

   logic [PHASE_W-1:0]        phase_eff;
   logic [BLINK_W-1:0]        blinks;
   logic [BLINK_W-1:0]        blinks_inc;
   logic                      lit;
   logic [TICK_COUNT_WIDTH-1:0] cnt;
   logic [TICK_COUNT_WIDTH:0] cnt_inc;
   logic [CFG_W-1:0]          limit;
   logic                      blinking;
   logic                      yel;
   logic                      span_done;
   logic [PHASE_W-1:0]        phase_adv;

   always_comb begin
      phase_eff = state_cur.phase;
      blinks    = state_cur.blinks_done;
      lit       = state_cur.yellow_lit;
      cnt       = count_cur;
      // unreachable codes fall back to car green
      if (phase_eff > PHASE_RESUME) begin
         phase_eff = PHASE_GREEN;
         blinks    = '0;
         lit       = 1'b0;
         cnt       = '0;
      end
      // press in normal mode jumps straight into the pedestrian sequence
      if (press && (phase_eff <= PHASE_RED_BLINK)) begin
         phase_eff = (phase_eff >= PHASE_RED) ? PHASE_CROSS : PHASE_WARN;
         blinks    = '0;
         lit       = 1'b0;
         cnt       = '0;
      end
   end

   assign blinking = is_blink(phase_eff);
   assign yel      = blinking & lit;

   always_comb begin
      result            = '0;
      result.phase_code = phase_eff;
      case (phase_eff)
         PHASE_GREEN: begin
            result.car_green = 1'b1;
         end
         PHASE_GREEN_BLINK: begin
            result.car_green  = 1'b1;
            result.car_yellow = yel;
         end
         PHASE_RED: begin
            result.car_red = 1'b1;
         end
         PHASE_RED_BLINK: begin
            result.car_red    = 1'b1;
            result.car_yellow = yel;
         end
         PHASE_WARN, PHASE_RESUME: begin
            result.car_green = 1'b1;
            result.walk_red  = 1'b1;
         end
         PHASE_WARN_BLINK: begin
            result.car_green   = 1'b1;
            result.walk_red    = 1'b1;
            result.car_yellow  = yel;
            result.walk_yellow = yel;
         end
         PHASE_CROSS: begin
            result.car_red    = 1'b1;
            result.walk_green = 1'b1;
         end
         PHASE_CROSS_BLINK: begin
            result.car_red     = 1'b1;
            result.walk_green  = 1'b1;
            result.car_yellow  = yel;
            result.walk_yellow = yel;
         end
         default: begin
            result.car_green = 1'b0;
         end
      endcase
   end

   // span timer: ends on reaching the limit or on counter overflow
   assign cnt_inc = {1'b0, cnt} + (TICK_COUNT_WIDTH+1)'(1);
   assign limit   = blinking ? min_one_len(cfg.blink_half_ticks) :
                    (phase_eff == PHASE_WARN) ? min_one_len(cfg.warning_ticks) :
                    min_one_len(cfg.long_phase_ticks);
   assign span_done = (CMP_W'(cnt_inc) >= CMP_W'(limit)) || cnt_inc[TICK_COUNT_WIDTH];
   assign blinks_inc = blinks + BLINK_W'(1);
   assign phase_adv  = next_phase(phase_eff);

   always_comb begin
      state_nxt.phase       = phase_eff;
      state_nxt.blinks_done = blinks;
      state_nxt.yellow_lit  = lit;
      count_nxt             = cnt_inc[TICK_COUNT_WIDTH-1:0];
      if (span_done) begin
         count_nxt = '0;
         if (!blinking || (!lit && (blinks_inc >= min_one_cnt(cfg.blink_cycles)))) begin
            state_nxt.phase       = phase_adv;
            state_nxt.blinks_done = '0;
            state_nxt.yellow_lit  = is_blink(phase_adv);
         end else if (lit) begin
            state_nxt.yellow_lit = 1'b0;
         end else begin
            state_nxt.blinks_done = blinks_inc;
            state_nxt.yellow_lit  = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

### hw/rtl/traffic_light_pedestrian_sequencer.sv
`default_nettype none
`include "traffic_light_pedestrian_sequencer_assert.svh"
// traffic light sequencer with pedestrian button: each req transaction is one time
// tick carrying the button flag, and each tick returns exactly one rsp transaction
// with the six lamps and the phase code shown in that tick. a tick passes through
// an input register, then the phase/timer logic, then the result register, and
// one tick is taken every cycle as long as rsp_ready keeps up; the only per-tick
// limit is the single phase and counter update. timing registers are written
// through the csr port (index 0 long phase, 1 warning, 2 blink half, 3 blink
// count); the user must write them only while no tick is in flight, which the
// block does not enforce. a value of zero acts as one. TICK_COUNT_WIDTH sets the
// tick counter; a span longer than it can count ends when the counter would wrap.
module traffic_light_pedestrian_sequencer #(
   parameter int TICK_COUNT_WIDTH = tlps_pkg::TICK_COUNT_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_button_press,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_car_green,
   output logic                                rsp_car_yellow,
   output logic                                rsp_car_red,
   output logic                                rsp_walk_green,
   output logic                                rsp_walk_yellow,
   output logic                                rsp_walk_red,
   output logic [tlps_pkg::PHASE_W-1:0]        rsp_phase_code,
   input  wire logic                           csr_wr_en,
   input  wire logic [tlps_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tlps_pkg::CFG_W-1:0]     csr_wr_data
);
   import tlps_pkg::*;

   tlps_cfg_type    cfg;

   // input stage
   logic            in_valid_ff;
   logic            in_valid_in;
   logic            press_ff;

   // sequencer state
   tlps_state_type  state_ff;
   tlps_state_type  state_in;
   logic [TICK_COUNT_WIDTH-1:0] count_ff;
   logic [TICK_COUNT_WIDTH-1:0] count_in;

   // result stage
   tlps_result_type result_in;
   tlps_result_type result_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;

   logic            out_free;
   logic            advance;
   logic            req_take;

   tlps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   tlps_step #(
      .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
   ) u_step (
      .press     (press_ff),
      .cfg       (cfg),
      .state_cur (state_ff),
      .count_cur (count_ff),
      .state_nxt (state_in),
      .count_nxt (count_in),
      .result    (result_in)
   );

   // result slot is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // the buffered tick is processed when its result has somewhere to go
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
            count_ff <= count_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         press_ff <= req_button_press;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_car_green   = result_ff.car_green;
   assign rsp_car_yellow  = result_ff.car_yellow;
   assign rsp_car_red     = result_ff.car_red;
   assign rsp_walk_green  = result_ff.walk_green;
   assign rsp_walk_yellow = result_ff.walk_yellow;
   assign rsp_walk_red    = result_ff.walk_red;
   assign rsp_phase_code  = result_ff.phase_code;

   // a processed tick always lands in the result register
   `TLPS_ASSERT_NEXT(a_advance_fills, advance, rsp_valid_ff)
   // a buffered tick that cannot move is kept
   `TLPS_ASSERT_NEXT(a_tick_held, in_valid_ff && !out_free, in_valid_ff)
   // exactly one car lamp of green and red is lit
   `TLPS_ASSERT_IMP(a_car_lamps, rsp_valid_ff, result_ff.car_green ^ result_ff.car_red)
   // walkers only get green while cars see red
   `TLPS_ASSERT_IMP(a_walk_safe, rsp_valid_ff && result_ff.walk_green, result_ff.car_red)
   // a press during car green shows the warning hold in the same tick
   `TLPS_ASSERT_NEXT(a_press_warn,
      advance && press_ff && (state_ff.phase <= PHASE_GREEN_BLINK),
      rsp_phase_code == PHASE_WARN)

endmodule
`default_nettype wire

### tb/lamp_checker.sv
module lamp_checker #(
   parameter int TICK_COUNT_WIDTH = tlps_pkg::TICK_COUNT_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire logic                           req_button_press,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire logic                           rsp_car_green,
   input  wire logic                           rsp_car_yellow,
   input  wire logic                           rsp_car_red,
   input  wire logic                           rsp_walk_green,
   input  wire logic                           rsp_walk_yellow,
   input  wire logic                           rsp_walk_red,
   input  wire logic [tlps_pkg::PHASE_W-1:0]   rsp_phase_code,
   input  wire logic                           csr_wr_en,
   input  wire logic [tlps_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tlps_pkg::CFG_W-1:0]     csr_wr_data,
   output int                                  ticks_in_flight,
   output int                                  fault_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import tlps_pkg::*;

   tlps_cfg_type                timing;
   logic [PHASE_W-1:0]          phase;
   logic [TICK_COUNT_WIDTH-1:0] tick_count;
   logic [BLINK_W-1:0]          blinks_done;
   logic                        yellow_lit;
   tlps_result_type             lamps_due [$];

   function automatic logic flashing(input logic [PHASE_W-1:0] p);
      return (p == PHASE_GREEN_BLINK) || (p == PHASE_RED_BLINK) ||
             (p == PHASE_WARN_BLINK) || (p == PHASE_CROSS_BLINK);
   endfunction

   function automatic logic [PHASE_W-1:0] phase_after(input logic [PHASE_W-1:0] p);
      case (p)
         PHASE_GREEN:       return PHASE_GREEN_BLINK;
         PHASE_GREEN_BLINK: return PHASE_RED;
         PHASE_RED:         return PHASE_RED_BLINK;
         PHASE_WARN:        return PHASE_WARN_BLINK;
         PHASE_WARN_BLINK:  return PHASE_CROSS;
         PHASE_CROSS:       return PHASE_CROSS_BLINK;
         PHASE_CROSS_BLINK: return PHASE_RESUME;
         default:           return PHASE_GREEN;
      endcase
   endfunction

   function automatic void start_phase(input logic [PHASE_W-1:0] p);
      phase       = p;
      tick_count  = '0;
      blinks_done = '0;
      yellow_lit  = flashing(p);
   endfunction

   // one tick: lamps shown now, then timer and phase advance
   function automatic tlps_result_type run_tick(input logic press);
      tlps_result_type   r;
      logic              lit;
      longint unsigned   next_count;
      longint unsigned   span;
      longint unsigned   count_max;
      longint unsigned   blink_goal;
      count_max = (64'd1 << TICK_COUNT_WIDTH) - 1;
      if (phase > PHASE_RESUME) start_phase(PHASE_GREEN);
      if (press && phase <= PHASE_RED_BLINK)
         start_phase((phase >= PHASE_RED) ? PHASE_CROSS : PHASE_WARN);

      lit           = flashing(phase) && yellow_lit;
      r.car_green   = (phase == PHASE_GREEN) || (phase == PHASE_GREEN_BLINK) ||
                      (phase == PHASE_WARN) || (phase == PHASE_WARN_BLINK) ||
                      (phase == PHASE_RESUME);
      r.car_yellow  = lit;
      r.car_red     = (phase == PHASE_RED) || (phase == PHASE_RED_BLINK) ||
                      (phase == PHASE_CROSS) || (phase == PHASE_CROSS_BLINK);
      r.walk_green  = (phase == PHASE_CROSS) || (phase == PHASE_CROSS_BLINK);
      r.walk_yellow = ((phase == PHASE_WARN_BLINK) || (phase == PHASE_CROSS_BLINK)) && lit;
      r.walk_red    = (phase == PHASE_WARN) || (phase == PHASE_WARN_BLINK) ||
                      (phase == PHASE_RESUME);
      r.phase_code  = phase;

      next_count = 64'(tick_count) + 1;
      if (flashing(phase)) begin
         span = (timing.blink_half_ticks == '0) ? 1 : timing.blink_half_ticks;
         if (next_count >= span || next_count > count_max) begin
            tick_count = '0;
            if (yellow_lit) begin
               yellow_lit = 1'b0;
            end else begin
               blinks_done = blinks_done + 1'b1;
               blink_goal  = (timing.blink_cycles == '0) ? 1 : timing.blink_cycles;
               if (blinks_done >= blink_goal) start_phase(phase_after(phase));
               else yellow_lit = 1'b1;
            end
         end else begin
            tick_count = TICK_COUNT_WIDTH'(next_count);
         end
      end else begin
         span = (phase == PHASE_WARN) ? timing.warning_ticks : timing.long_phase_ticks;
         if (span == 0) span = 1;
         if (next_count >= span || next_count > count_max) start_phase(phase_after(phase));
         else tick_count = TICK_COUNT_WIDTH'(next_count);
      end
      return r;
   endfunction

   task automatic compare_lamp(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      tlps_result_type shown;
      tlps_result_type want;
      if (reset) begin
         lamps_due.delete();
         fault_count = 0;
         timing = '{LONG_PHASE_RST, WARNING_RST, BLINK_HALF_RST, BLINK_COUNT_RST};
         start_phase(PHASE_GREEN);
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LONG_PHASE:  timing.long_phase_ticks = csr_wr_data;
               CSR_WARNING:     timing.warning_ticks    = csr_wr_data;
               CSR_BLINK_HALF:  timing.blink_half_ticks = csr_wr_data;
               CSR_BLINK_COUNT: timing.blink_cycles     = csr_wr_data[BLINK_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            shown = '{rsp_car_green, rsp_car_yellow, rsp_car_red, rsp_walk_green,
                      rsp_walk_yellow, rsp_walk_red, rsp_phase_code};
            if (lamps_due.size() == 0) begin
               $error("lamp transaction with no tick outstanding, phase_code %0d",
                      rsp_phase_code);
               fault_count++;
            end else begin
               want = lamps_due.pop_front();
               compare_lamp("car_green", want.car_green, shown.car_green);
               compare_lamp("car_yellow", want.car_yellow, shown.car_yellow);
               compare_lamp("car_red", want.car_red, shown.car_red);
               compare_lamp("walk_green", want.walk_green, shown.walk_green);
               compare_lamp("walk_yellow", want.walk_yellow, shown.walk_yellow);
               compare_lamp("walk_red", want.walk_red, shown.walk_red);
               compare_lamp("phase_code", want.phase_code, shown.phase_code);
            end
         end
         if (req_valid && req_ready) lamps_due.push_back(run_tick(req_button_press));
      end
      ticks_in_flight = lamps_due.size();
   end

endmodule

### tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tlps_pkg::*;

   localparam int          IDLE_PCT      = 12;     // chance of an idle cycle, per hundred
   localparam int          RSP_HOLD      = 60;     // long receiver hold-off, in cycles
   localparam int          RANDOM_SETS   = 12;
   localparam int          SET_TICKS     = 120;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   // press pattern for the all-zero timing run: presses ignored in the warn blink
   // and the cross, then two in red blink (bit i is tick i)
   localparam logic [19:0] ZERO_RUN_PRESS = 20'h8080A;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic                 req_button_press = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic                 rsp_car_green;
   logic                 rsp_car_yellow;
   logic                 rsp_car_red;
   logic                 rsp_walk_green;
   logic                 rsp_walk_yellow;
   logic                 rsp_walk_red;
   logic [PHASE_W-1:0]   rsp_phase_code;
   logic                 csr_wr_en        = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = CSR_LONG_PHASE;
   logic [CFG_W-1:0]     csr_wr_data      = '0;

   int                   ticks_in_flight;
   int                   fault_count;

   // steady: no idling on either side; hold_wanted: ask the receiver for one long hold-off
   bit                   steady           = 1'b0;
   bit                   hold_wanted      = 1'b0;

   traffic_light_pedestrian_sequencer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_button_press (req_button_press),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_car_green    (rsp_car_green),
      .rsp_car_yellow   (rsp_car_yellow),
      .rsp_car_red      (rsp_car_red),
      .rsp_walk_green   (rsp_walk_green),
      .rsp_walk_yellow  (rsp_walk_yellow),
      .rsp_walk_red     (rsp_walk_red),
      .rsp_phase_code   (rsp_phase_code),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   // watches both channels and the csr port, predicts every lamp transaction
   lamp_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_button_press (req_button_press),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_car_green    (rsp_car_green),
      .rsp_car_yellow   (rsp_car_yellow),
      .rsp_car_red      (rsp_car_red),
      .rsp_walk_green   (rsp_walk_green),
      .rsp_walk_yellow  (rsp_walk_yellow),
      .rsp_walk_red     (rsp_walk_red),
      .rsp_phase_code   (rsp_phase_code),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .ticks_in_flight  (ticks_in_flight),
      .fault_count      (fault_count)
   );

   // 4 ns clock
   always #2 clock = ~clock;

   // synchronous reset, released on a falling edge
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // wait at falling edges until every predicted lamp transaction has come back
   task automatic wait_drained();
      while (ticks_in_flight != 0) @(negedge clock);
   endtask

   // offer one tick transaction; called and returns on a falling edge
   // drain_first: drop valid and let the block empty out before offering
   task automatic offer_tick(input logic press, input bit drain_first);
      int gap;
      gap = (!steady && $urandom_range(99) < IDLE_PCT) ? $urandom_range(1, 3) : 0;
      if (drain_first && gap == 0) gap = 1;
      if (gap > 0) begin
         req_valid        <= 1'b0;
         req_button_press <= 1'($urandom_range(1));   // noise while not valid
         repeat (gap) @(negedge clock);
         if (drain_first) wait_drained();
      end
      req_valid        <= 1'b1;
      req_button_press <= press;
      // hold valid and payload until the handshake
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
   endtask

   // timing registers only change with nothing in flight
   task automatic apply_settings(input logic [CFG_W-1:0] long_len, input logic [CFG_W-1:0] warn_len,
                                 input logic [CFG_W-1:0] half_len, input logic [CFG_W-1:0] blink_raw);
      logic [CFG_W-1:0]     value [4];
      logic [CSR_IDX_W-1:0] slot [4];
      value = '{long_len, warn_len, half_len, blink_raw};
      slot  = '{CSR_LONG_PHASE, CSR_WARNING, CSR_BLINK_HALF, CSR_BLINK_COUNT};
      req_valid <= 1'b0;
      wait_drained();
      for (int i = 0; i < 4; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= slot[i];
         csr_wr_data <= value[i];
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   // receiver: random stalls, one long hold-off on request, none while steady
   initial begin : receiver
      bit hold_served;
      hold_served = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_wanted && !hold_served) begin
            hold_served = 1'b1;
            rsp_ready <= 1'b0;
            // block fills up and must stall the tick channel meanwhile
            repeat (RSP_HOLD) @(negedge clock);
         end
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // stimulus
   initial begin : stimulus
      int               press_odds;
      logic [CFG_W-1:0] long_len;
      logic [CFG_W-1:0] warn_len;
      logic [CFG_W-1:0] half_len;
      logic [CFG_W-1:0] blink_raw;
      @(negedge clock);
      while (reset) @(negedge clock);

      // power-up timing: steady green, a press in green, a press ignored in warn
      offer_tick(1'b0, 1'b0);
      offer_tick(1'b0, 1'b0);
      offer_tick(1'b0, 1'b0);
      offer_tick(1'b1, 1'b0);
      offer_tick(1'b1, 1'b0);

      // all registers zero, each acts as one: short phases, every transition
      apply_settings('0, '0, '0, '0);
      for (int i = 0; i < 20; i++) offer_tick(ZERO_RUN_PRESS[i], 1'b0);

      // all registers at their top, upper csr bits of the blink count set too
      apply_settings('1, '1, '1, '1);
      for (int i = 0; i < 40; i++) offer_tick($urandom_range(29) == 0, 1'b0);

      // random short timings so that whole cycles and pedestrian sequences complete
      for (int set = 0; set < RANDOM_SETS; set++) begin
         long_len  = CFG_W'($urandom_range(0, 14));
         warn_len  = CFG_W'($urandom_range(0, 8));
         half_len  = CFG_W'($urandom_range(0, 3));
         blink_raw = CFG_W'($urandom_range(0, 16'hFFFF));
         if (set == 3) begin
            // longest blink phase: fifteen single-tick blinks
            half_len  = CFG_W'(1);
            blink_raw = {blink_raw[CFG_W-1:BLINK_W], 4'hF};
         end
         apply_settings(long_len, warn_len, half_len, blink_raw);
         press_odds = $urandom_range(3, 40);
         steady     = (set == 5);
         for (int n = 0; n < SET_TICKS; n++) begin
            if (set == 2 && n == 30) hold_wanted = 1'b1;
            offer_tick($urandom_range(press_odds - 1) == 0, set == 7 && n == 60);
         end
      end
      steady = 1'b0;

      req_valid <= 1'b0;
      wait_drained();
      repeat (4) @(negedge clock);   // room for a stray extra transaction to show up
      if (fault_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   // run limit, far above the slowest correct run
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

endmodule
